[hdl/iracf_pkg.sv]
// ----------------------------------------------------------------------------
// IR sensor ambient-cancel filter: shared definitions
// Field widths, schedule phase codes, register indexes and the small helper
// functions used across the filter block.
// ----------------------------------------------------------------------------
package iracf_pkg;

  // Sample and level widths
  localparam int ADC_W   = 12;
  localparam int ADC_MAX = 4095;
  localparam int PHASE_W = 3;

  // Stream payload widths (byte padded)
  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 2;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RIGHT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LEFT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_FRONT_RIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_FRONT_LEFT  = 3'd3;

  // Item kind carried on the input user field
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_CAPTURE = 1'b1;

  // Schedule phases
  localparam logic [PHASE_W-1:0] PH_SIDE_OFF      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SIDE_OFF_CAP  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SIDE_ON       = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SIDE_ON_CAP   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FRONT_OFF     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_FRONT_OFF_CAP = 3'd5;
  localparam logic [PHASE_W-1:0] PH_FRONT_ON      = 3'd6;
  localparam logic [PHASE_W-1:0] PH_FRONT_ON_CAP  = 3'd7;

  // Average of two paired ADC ranks.
  function automatic logic [ADC_W-1:0] pair_avg(input logic [ADC_W-1:0] a,
                                                input logic [ADC_W-1:0] b);
    logic [ADC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ADC_W:1];
  endfunction

  // Emitter-on sample minus ambient and offset, clamped at zero.
  function automatic logic [ADC_W-1:0] cancel_lvl(input logic [ADC_W-1:0] on_v,
                                                  input logic [ADC_W-1:0] amb,
                                                  input logic [ADC_W-1:0] off);
    logic [ADC_W:0] sub;
    logic [ADC_W:0] diff;
    sub  = {1'b0, amb} + {1'b0, off};
    diff = {1'b0, on_v} - sub;
    return ({1'b0, on_v} > sub) ? diff[ADC_W-1:0] : '0;
  endfunction

endpackage

[hdl/iracf_div.sv]
// ----------------------------------------------------------------------------
// IR sensor ambient-cancel filter: serial divider
// Restoring divider producing one quotient bit per cycle, used to scale the
// running sums by the number of samples held in the averaging window.
// ----------------------------------------------------------------------------
module iracf_div #(
  parameter int DIVIDEND_W = 14,
  parameter int DIVISOR_W  = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_r;
  logic                  active_r;
  logic                  done_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  qbit;

  // One trial subtraction per cycle
  always_comb begin
    trial     = {rem_r, quo_r[DIVIDEND_W-1]};
    qbit      = (trial >= {1'b0, divisor});
    trial_sub = trial - {1'b0, divisor};
  end

  // Control: iteration counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r    <= CNT_W'(DIVIDEND_W);
        active_r <= 1'b1;
      end else if (active_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (active_r) begin
      rem_r <= qbit ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], qbit};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hdl/ir_sensor_ambient_cancel_filter.sv]
// Path: a tick, or a capture that only stores ambient levels, goes through
// ST_DONE to the output register once it is free; an emitter-on capture first
// passes the history read and update states and the serial divider of the average.
// Throughput: one item at a time; the next input is taken once the previous
// one has been handed to the output register, which may still be waiting.
// Reset: synchronous, active low; clears control, filter and level state, history valid bits at once.
// ----------------------------------------------------------------------------
// IR sensor ambient-cancel filter: top level
// Eight-phase emitter and capture sequencer with ambient cancellation and a
// moving average per channel whose history lives in a synchronous RAM.
// ----------------------------------------------------------------------------
module ir_sensor_ambient_cancel_filter #(
  parameter int TAPS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata from bit 0: rank_r_a, rank_l_a, rank_r_b, rank_l_b, rank_fr_a,
  // rank_fl_a, rank_fr_b, rank_fl_b, rank_battery, zero padding
  input  logic [iracf_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser from bit 0: func
  input  logic [iracf_pkg::IN_USER_W-1:0]      in_tuser,
  // Result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata from bit 0: side_emitters_on, front_emitters_on, start_capture,
  // level_right, level_left, level_front_right, level_front_left,
  // battery_level, phase_now, zero padding
  output logic [iracf_pkg::OUT_DATA_W-1:0]     out_tdata,
  // tuser from bit 0: side_updated, front_updated
  output logic [iracf_pkg::OUT_USER_W-1:0]     out_tuser,
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [iracf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iracf_pkg::ADC_W-1:0]          cfg_data
);

  localparam int ADC_W   = iracf_pkg::ADC_W;
  localparam int PHASE_W = iracf_pkg::PHASE_W;
  localparam int SUM_W   = $clog2(TAPS * iracf_pkg::ADC_MAX + 1);
  localparam int FILL_W  = $clog2(TAPS + 1);
  localparam int POS_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int DEPTH   = 4 * TAPS;
  localparam int ADDR_W  = $clog2(DEPTH);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_RD_A     = 7'b0000010,
    ST_RD_B     = 7'b0000100,
    ST_UPD_B    = 7'b0001000,
    ST_DIV_GO   = 7'b0010000,
    ST_DIV_WAIT = 7'b0100000,
    ST_DONE     = 7'b1000000
  } st_t;

  // Control state
  st_t                st_r, st_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               busy_r, busy_nxt;
  logic               side_led_r, side_led_nxt;
  logic               front_led_r, front_led_nxt;
  logic               start_r, start_nxt;
  logic               side_upd_r, side_upd_nxt;
  logic               front_upd_r, front_upd_nxt;
  logic               out_valid_r;

  // Stored levels and filter state
  logic [ADC_W-1:0]   offset_r   [4];
  logic [ADC_W-1:0]   amb_r      [4];
  logic [ADC_W-1:0]   level_r    [4];
  logic [SUM_W-1:0]   sum_r      [4];
  logic [POS_W-1:0]   pos_r      [2];
  logic [FILL_W-1:0]  fill_r     [2];
  logic [ADC_W-1:0]   battery_r;

  // Working registers of the current item
  logic               grp_r;
  logic [ADC_W-1:0]   avg_a_r, avg_b_r;
  logic [ADC_W-1:0]   va_r, vb_r;

  // History RAM and its valid bits
  logic [ADC_W-1:0]   hist_mem [DEPTH];
  logic [DEPTH-1:0]   hist_vld_r;
  logic [ADC_W-1:0]   hist_q_r;
  logic               hist_vq_r;
  logic [ADDR_W-1:0]  hist_raddr, hist_waddr;
  logic               hist_we;
  logic [ADC_W-1:0]   hist_wdata, hist_rd;
  logic [ADDR_W-1:0]  addr_a, addr_b;

  // Decoded input fields
  logic               in_acc, func;
  logic [ADC_W-1:0]   avg_r, avg_l, avg_fr, avg_fl;
  logic [ADC_W-1:0]   ca, cb;
  logic [SUM_W:0]     sum_upd;
  logic [SUM_W-1:0]   sum_old;
  logic               out_free;

  // Dividers
  logic               div_start, done_a, done_b;
  logic [SUM_W-1:0]   quo_a, quo_b;

  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign func      = in_tuser[0];
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  assign avg_r  = iracf_pkg::pair_avg(in_tdata[11:0],  in_tdata[35:24]);
  assign avg_l  = iracf_pkg::pair_avg(in_tdata[23:12], in_tdata[47:36]);
  assign avg_fr = iracf_pkg::pair_avg(in_tdata[59:48], in_tdata[83:72]);
  assign avg_fl = iracf_pkg::pair_avg(in_tdata[71:60], in_tdata[95:84]);

  // Sequencer: item decode on transfer, then the filter steps
  always_comb begin
    st_nxt        = st_r;
    phase_nxt     = phase_r;
    busy_nxt      = busy_r;
    side_led_nxt  = side_led_r;
    front_led_nxt = front_led_r;
    start_nxt     = start_r;
    side_upd_nxt  = side_upd_r;
    front_upd_nxt = front_upd_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          start_nxt     = 1'b0;
          side_upd_nxt  = 1'b0;
          front_upd_nxt = 1'b0;
          st_nxt        = ST_DONE;
          if (func == iracf_pkg::FUNC_TICK) begin
            if (!busy_r) begin
              if (phase_r[0]) begin
                start_nxt = 1'b1;
                busy_nxt  = 1'b1;
              end else begin
                case (phase_r)
                  iracf_pkg::PH_SIDE_OFF:  side_led_nxt  = 1'b0;
                  iracf_pkg::PH_SIDE_ON:   side_led_nxt  = 1'b1;
                  iracf_pkg::PH_FRONT_OFF: front_led_nxt = 1'b0;
                  default:                 front_led_nxt = 1'b1;
                endcase
                phase_nxt = phase_r + 1'b1;
              end
            end
          end else if (busy_r) begin
            busy_nxt  = 1'b0;
            phase_nxt = phase_r + 1'b1;
            if (phase_r == iracf_pkg::PH_SIDE_ON_CAP) begin
              side_led_nxt = 1'b0;
              side_upd_nxt = 1'b1;
              st_nxt       = ST_RD_A;
            end else if (phase_r == iracf_pkg::PH_FRONT_ON_CAP) begin
              front_led_nxt = 1'b0;
              front_upd_nxt = 1'b1;
              st_nxt        = ST_RD_A;
            end
          end
        end
      end
      ST_RD_A:     st_nxt = ST_RD_B;
      ST_RD_B:     st_nxt = ST_UPD_B;
      ST_UPD_B:    st_nxt = ST_DIV_GO;
      ST_DIV_GO:   st_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (done_a && done_b) st_nxt = ST_DONE;
      ST_DONE:     if (out_free) st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      phase_r     <= iracf_pkg::PH_SIDE_OFF;
      busy_r      <= 1'b0;
      side_led_r  <= 1'b0;
      front_led_r <= 1'b0;
      start_r     <= 1'b0;
      side_upd_r  <= 1'b0;
      front_upd_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      busy_r      <= busy_nxt;
      side_led_r  <= side_led_nxt;
      front_led_r <= front_led_nxt;
      start_r     <= start_nxt;
      side_upd_r  <= side_upd_nxt;
      front_upd_r <= front_upd_nxt;
    end
  end

  // Offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) offset_r[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        iracf_pkg::CFG_OFFSET_RIGHT:       offset_r[0] <= cfg_data;
        iracf_pkg::CFG_OFFSET_LEFT:        offset_r[1] <= cfg_data;
        iracf_pkg::CFG_OFFSET_FRONT_RIGHT: offset_r[2] <= cfg_data;
        iracf_pkg::CFG_OFFSET_FRONT_LEFT:  offset_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ambient levels and battery sample from emitter-off captures
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) amb_r[i] <= '0;
      battery_r <= '0;
    end else if (in_acc && func == iracf_pkg::FUNC_CAPTURE && busy_r) begin
      if (phase_r == iracf_pkg::PH_SIDE_OFF_CAP) begin
        amb_r[0] <= avg_r;
        amb_r[1] <= avg_l;
      end else if (phase_r == iracf_pkg::PH_FRONT_OFF_CAP) begin
        amb_r[2]  <= avg_fr;
        amb_r[3]  <= avg_fl;
        battery_r <= in_tdata[107:96];
      end
    end
  end

  // Emitter-on averages of the group being filtered
  always_ff @(posedge clk) begin
    if (in_acc) begin
      grp_r   <= phase_r[2];
      avg_a_r <= phase_r[2] ? avg_fr : avg_r;
      avg_b_r <= phase_r[2] ? avg_fl : avg_l;
    end
  end

  // Ambient and offset cancellation
  assign ca = iracf_pkg::cancel_lvl(avg_a_r, amb_r[{grp_r, 1'b0}], offset_r[{grp_r, 1'b0}]);
  assign cb = iracf_pkg::cancel_lvl(avg_b_r, amb_r[{grp_r, 1'b1}], offset_r[{grp_r, 1'b1}]);

  always_ff @(posedge clk) begin
    if (st_r == ST_RD_A) begin
      va_r <= ca;
      vb_r <= cb;
    end
  end

  // History addresses: channel times window length plus ring position
  assign addr_a = ADDR_W'({grp_r, 1'b0}) * ADDR_W'(TAPS) + ADDR_W'(pos_r[grp_r]);
  assign addr_b = ADDR_W'({grp_r, 1'b1}) * ADDR_W'(TAPS) + ADDR_W'(pos_r[grp_r]);

  assign hist_raddr = (st_r == ST_RD_B) ? addr_b : addr_a;
  assign hist_we    = (st_r == ST_RD_B) || (st_r == ST_UPD_B);
  assign hist_waddr = (st_r == ST_RD_B) ? addr_a : addr_b;
  assign hist_wdata = (st_r == ST_RD_B) ? va_r : vb_r;
  assign hist_rd    = hist_vq_r ? hist_q_r : '0;

  // History RAM, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_q_r <= hist_mem[hist_raddr];
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
      hist_vq_r  <= 1'b0;
    end else begin
      if (hist_we) hist_vld_r[hist_waddr] <= 1'b1;
      hist_vq_r <= hist_vld_r[hist_raddr];
    end
  end

  // Running sum update: add the new sample, drop the oldest one
  always_comb begin
    sum_old = (st_r == ST_RD_B) ? sum_r[{grp_r, 1'b0}] : sum_r[{grp_r, 1'b1}];
    sum_upd = {1'b0, sum_old} + (SUM_W + 1)'(hist_wdata) - (SUM_W + 1)'(hist_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) sum_r[i] <= '0;
      for (int g = 0; g < 2; g++) begin
        pos_r[g]  <= '0;
        fill_r[g] <= '0;
      end
    end else if (st_r == ST_RD_B) begin
      sum_r[{grp_r, 1'b0}] <= sum_upd[SUM_W-1:0];
    end else if (st_r == ST_UPD_B) begin
      sum_r[{grp_r, 1'b1}] <= sum_upd[SUM_W-1:0];
      if (fill_r[grp_r] < FILL_W'(TAPS)) fill_r[grp_r] <= fill_r[grp_r] + 1'b1;
      if (pos_r[grp_r] == POS_W'(TAPS - 1)) pos_r[grp_r] <= '0;
      else pos_r[grp_r] <= pos_r[grp_r] + 1'b1;
    end
  end

  // Average: both channels of the group divided by the window fill
  assign div_start = (st_r == ST_DIV_GO);

  iracf_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (FILL_W)
  ) u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[{grp_r, 1'b0}]),
    .divisor  (fill_r[grp_r]),
    .done     (done_a),
    .quotient (quo_a)
  );

  iracf_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (FILL_W)
  ) u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[{grp_r, 1'b1}]),
    .divisor  (fill_r[grp_r]),
    .done     (done_b),
    .quotient (quo_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) level_r[i] <= '0;
    end else if (st_r == ST_DIV_WAIT && done_a && done_b) begin
      level_r[{grp_r, 1'b0}] <= quo_a[ADC_W-1:0];
      level_r[{grp_r, 1'b1}] <= quo_b[ADC_W-1:0];
    end
  end

  // Output register: loaded once the item is complete and the slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_DONE && out_free) begin
      out_tdata <= {6'd0, phase_r, battery_r, level_r[3], level_r[2], level_r[1],
                    level_r[0], start_r, front_led_r, side_led_r};
      out_tuser <= {front_upd_r, side_upd_r};
    end
  end

  assign out_tvalid = out_valid_r;

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (done_a || done_b) |-> (st_r == ST_DIV_WAIT))
    else $error("divider completed outside its wait state");

  // A history write never targets the entry being read in the same cycle.
  a_hist_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |-> (hist_raddr != hist_waddr))
    else $error("history read and write collide on one entry");

  // The window fill never exceeds the number of taps.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= FILL_W'(TAPS)) && (fill_r[1] <= FILL_W'(TAPS)))
    else $error("window fill count beyond tap count");

  // A capture request leaves the sequencer busy in a capture phase.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && start_r) |-> (busy_r && phase_r[0]))
    else $error("capture requested without busy capture phase");

endmodule

[bench/tb_ir_sensor_ambient_cancel_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR sensor ambient-cancel filter: testbench
// Drives scheduler ticks and capture completions into the sequencer and runs
// its own copy of the phase schedule, ambient cancellation and moving average
// alongside it. Every transfer out of the block is compared field by field with
// the oldest predicted result. The offsets are reloaded between settings while
// the block is idle. Both stream sides idle at random, and one long
// back-pressure stretch fills the block.
// ----------------------------------------------------------------------------
module tb_ir_sensor_ambient_cancel_filter;

  localparam int ADC_W         = iracf_pkg::ADC_W;
  localparam int ADC_MAX       = iracf_pkg::ADC_MAX;
  localparam int PHASE_W       = iracf_pkg::PHASE_W;
  localparam int IN_DATA_W     = iracf_pkg::IN_DATA_W;
  localparam int IN_USER_W     = iracf_pkg::IN_USER_W;
  localparam int OUT_DATA_W    = iracf_pkg::OUT_DATA_W;
  localparam int OUT_USER_W    = iracf_pkg::OUT_USER_W;
  localparam int CFG_IDX_W     = iracf_pkg::CFG_IDX_W;
  localparam int TAPS          = 4;
  localparam int RES_DATA_BITS = 5 * ADC_W + PHASE_W + 3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int GAP_PERCENT   = 34;
  localparam int BUSY_FROM     = 400;
  localparam int BUSY_TO       = 520;
  localparam int HOLD_AT       = 250;
  localparam int HOLD_LENGTH   = 300;
  localparam int ROUNDS_EACH   = 65;

  // One input item: the kind and the nine ADC ranks, rank 0 in the lowest bits.
  typedef struct packed {
    logic                  func;
    logic [8:0][ADC_W-1:0] rank;
  } sensor_item_t;

  // One result, laid out as {tuser, tdata} without the padding.
  typedef struct packed {
    logic               front_upd;
    logic               side_upd;
    logic [PHASE_W-1:0] phase;
    logic [ADC_W-1:0]   battery;
    logic [ADC_W-1:0]   lvl_fl;
    logic [ADC_W-1:0]   lvl_fr;
    logic [ADC_W-1:0]   lvl_l;
    logic [ADC_W-1:0]   lvl_r;
    logic               start;
    logic               front_on;
    logic               side_on;
  } level_result_t;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata  = '0;
  logic [IN_USER_W-1:0]    in_tuser  = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic [OUT_USER_W-1:0]   out_tuser;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [ADC_W-1:0]        cfg_data  = '0;

  ir_sensor_ambient_cancel_filter #(.TAPS(TAPS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow state of the sequencer and the averaging stores.
  logic [PHASE_W-1:0] sched_phase     = '0;
  logic               capture_pending = 1'b0;
  logic               side_drive      = 1'b0;
  logic               front_drive     = 1'b0;
  int                 ambient_hold[4] = '{default: 0};
  int                 battery_copy    = 0;
  int                 tap_store[4*TAPS] = '{default: 0};
  int                 tap_sum[4]      = '{default: 0};
  int                 tap_pos[2]      = '{default: 0};
  int                 tap_fill[2]     = '{default: 0};
  int                 level_copy[4]   = '{default: 0};
  int                 offset_copy[4]  = '{default: 0};

  sensor_item_t  sensor_items[$];
  level_result_t awaited_levels[$];
  sensor_item_t  offered;
  level_result_t predicted;
  level_result_t seen;
  level_result_t want;

  int  accepted_items   = 0;
  int  results_seen     = 0;
  int  mismatches       = 0;
  int  cycles           = 0;
  int  hold_cycles_left = 0;
  bit  hold_done        = 1'b0;
  bit  send_gap;

  function automatic int pair_mean(logic [ADC_W-1:0] a, logic [ADC_W-1:0] b);
    return (int'(a) + int'(b)) / 2;
  endfunction

  // Emitter-on level with ambient and offset removed, never below zero.
  function automatic int ambient_removed(int on_v, int amb, int offs);
    int rest;
    rest = on_v - amb - offs;
    return (rest > 0) ? rest : 0;
  endfunction

  // Push one sample pair into a group's ring and refresh its averaged levels.
  function automatic void smooth_pair(int g, int va, int vb);
    int pos;
    int ch;
    pos = tap_pos[g];
    ch  = 2 * g;
    tap_sum[ch]     = tap_sum[ch] + va - tap_store[ch*TAPS + pos];
    tap_sum[ch + 1] = tap_sum[ch + 1] + vb - tap_store[(ch + 1)*TAPS + pos];
    tap_store[ch*TAPS + pos]       = va;
    tap_store[(ch + 1)*TAPS + pos] = vb;
    if (tap_fill[g] < TAPS) tap_fill[g]++;
    tap_pos[g] = (pos + 1) % TAPS;
    level_copy[ch]     = (tap_sum[ch] / tap_fill[g]) & ADC_MAX;
    level_copy[ch + 1] = (tap_sum[ch + 1] / tap_fill[g]) & ADC_MAX;
  endfunction

  // Advance the shadow schedule by one accepted item and form its result.
  function automatic level_result_t next_levels(sensor_item_t it);
    level_result_t r;
    logic [PHASE_W-1:0] p;
    int avg_r, avg_l, avg_fr, avg_fl;
    r = '0;
    p = sched_phase;
    if (it.func == iracf_pkg::FUNC_TICK) begin
      if (!capture_pending) begin
        if (p[0]) begin
          r.start = 1'b1;
          capture_pending = 1'b1;
        end else begin
          case (p)
            iracf_pkg::PH_SIDE_OFF:  side_drive  = 1'b0;
            iracf_pkg::PH_SIDE_ON:   side_drive  = 1'b1;
            iracf_pkg::PH_FRONT_OFF: front_drive = 1'b0;
            default:                 front_drive = 1'b1;
          endcase
          sched_phase = p + 1'b1;
        end
      end
    end else if (capture_pending) begin
      avg_r  = pair_mean(it.rank[0], it.rank[2]);
      avg_l  = pair_mean(it.rank[1], it.rank[3]);
      avg_fr = pair_mean(it.rank[4], it.rank[6]);
      avg_fl = pair_mean(it.rank[5], it.rank[7]);
      case (p)
        iracf_pkg::PH_SIDE_OFF_CAP: begin
          ambient_hold[0] = avg_r;
          ambient_hold[1] = avg_l;
        end
        iracf_pkg::PH_FRONT_OFF_CAP: begin
          ambient_hold[2] = avg_fr;
          ambient_hold[3] = avg_fl;
          battery_copy    = int'(it.rank[8]);
        end
        iracf_pkg::PH_SIDE_ON_CAP: begin
          smooth_pair(0, ambient_removed(avg_r, ambient_hold[0], offset_copy[0]),
                      ambient_removed(avg_l, ambient_hold[1], offset_copy[1]));
          side_drive = 1'b0;
          r.side_upd = 1'b1;
        end
        iracf_pkg::PH_FRONT_ON_CAP: begin
          smooth_pair(1, ambient_removed(avg_fr, ambient_hold[2], offset_copy[2]),
                      ambient_removed(avg_fl, ambient_hold[3], offset_copy[3]));
          front_drive = 1'b0;
          r.front_upd = 1'b1;
        end
        default: ;
      endcase
      capture_pending = 1'b0;
      sched_phase     = p + 1'b1;
    end
    r.side_on  = side_drive;
    r.front_on = front_drive;
    r.lvl_r    = ADC_W'(level_copy[0]);
    r.lvl_l    = ADC_W'(level_copy[1]);
    r.lvl_fr   = ADC_W'(level_copy[2]);
    r.lvl_fl   = ADC_W'(level_copy[3]);
    r.battery  = ADC_W'(battery_copy);
    r.phase    = sched_phase;
    return r;
  endfunction

  // Sample values: full range, small, hard extremes, or close to mid-scale.
  function automatic logic [ADC_W-1:0] draw_sample(int mode);
    case (mode)
      0:       return ADC_W'($urandom_range(ADC_MAX, 0));
      1:       return ADC_W'($urandom_range(255, 0));
      2:       return $urandom_range(1, 0) ? ADC_W'(ADC_MAX) : '0;
      default: return ADC_W'($urandom_range(2111, 1984));
    endcase
  endfunction

  function automatic sensor_item_t random_item(logic kind);
    sensor_item_t it;
    int mode;
    mode = int'($urandom_range(99));
    mode = (mode < 40) ? 0 : (mode < 70) ? 1 : (mode < 85) ? 2 : 3;
    it.func = kind;
    for (int i = 0; i < 9; i++) it.rank[i] = draw_sample(mode);
    return it;
  endfunction

  function automatic void push_fixed(logic kind, logic [8:0][ADC_W-1:0] ranks);
    sensor_item_t it;
    it.func = kind;
    it.rank = ranks;
    sensor_items.push_back(it);
  endfunction

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Register write through the configuration channel; the shadow copy follows.
  task automatic write_offset(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[ADC_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    offset_copy[idx] = value & ADC_MAX;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained;
    while (sensor_items.size() != 0 || in_tvalid || awaited_levels.size() != 0)
      @(posedge clk);
  endtask

  function automatic int pick_offset(int setting);
    case (setting)
      0:       return 0;
      1:       return ADC_MAX;
      2:       return int'($urandom_range(200, 0));
      default: return int'($urandom_range(ADC_MAX, 0));
    endcase
  endfunction

  // Input driver: offers queued items, predicts each one as it transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predicted = next_levels(offered);
        awaited_levels.push_back(predicted);
        accepted_items++;
      end
      if (!in_tvalid || in_tready) begin
        send_gap = ($urandom_range(99) < GAP_PERCENT) &&
                   !(accepted_items >= BUSY_FROM && accepted_items < BUSY_TO);
        if (sensor_items.size() != 0 && !send_gap) begin
          offered = sensor_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_DATA_W - 9*ADC_W){1'b0}}, offered.rank};
          in_tuser  <= offered.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer and drives back-pressure.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = {out_tuser, out_tdata[RES_DATA_BITS-1:0]};
      if (awaited_levels.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = awaited_levels.pop_front();
        check_field("side_emitters_on", int'(want.side_on), int'(seen.side_on));
        check_field("front_emitters_on", int'(want.front_on), int'(seen.front_on));
        check_field("start_capture", int'(want.start), int'(seen.start));
        check_field("side_updated", int'(want.side_upd), int'(seen.side_upd));
        check_field("front_updated", int'(want.front_upd), int'(seen.front_upd));
        check_field("level_right", int'(want.lvl_r), int'(seen.lvl_r));
        check_field("level_left", int'(want.lvl_l), int'(seen.lvl_l));
        check_field("level_front_right", int'(want.lvl_fr), int'(seen.lvl_fr));
        check_field("level_front_left", int'(want.lvl_fl), int'(seen.lvl_fl));
        check_field("battery_level", int'(want.battery), int'(seen.battery));
        check_field("phase_now", int'(want.phase), int'(seen.phase));
      end
      results_seen++;
    end
    // One long hold lets the block fill up and stall its input.
    if (hold_cycles_left != 0) begin
      hold_cycles_left--;
      out_tready <= 1'b0;
    end else if (results_seen == HOLD_AT && !hold_done) begin
      hold_done        = 1'b1;
      hold_cycles_left = HOLD_LENGTH;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(($urandom_range(99) < GAP_PERCENT) &&
                      !(results_seen >= BUSY_FROM && results_seen < BUSY_TO));
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus: reset, then four offset settings, each followed by its items.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int setting = 0; setting < 4; setting++) begin
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clk);
      write_offset(iracf_pkg::CFG_OFFSET_RIGHT, pick_offset(setting));
      write_offset(iracf_pkg::CFG_OFFSET_LEFT, pick_offset(setting));
      write_offset(iracf_pkg::CFG_OFFSET_FRONT_RIGHT, pick_offset(setting));
      write_offset(iracf_pkg::CFG_OFFSET_FRONT_LEFT, pick_offset(setting));

      if (setting == 0) begin
        // Completion while idle is ignored; a tick while busy changes nothing.
        push_fixed(iracf_pkg::FUNC_CAPTURE, {9{12'hFFF}});
        push_fixed(iracf_pkg::FUNC_TICK, '0);
        push_fixed(iracf_pkg::FUNC_TICK, '0);
        push_fixed(iracf_pkg::FUNC_TICK, {9{12'hFFF}});
        // Side ambient: odd pair sum on the right, near zero on the left.
        push_fixed(iracf_pkg::FUNC_CAPTURE, {12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
                                             12'd1, 12'd4094, 12'd0, 12'd4095});
        push_fixed(iracf_pkg::FUNC_TICK, '0);
        push_fixed(iracf_pkg::FUNC_TICK, '0);
        // Right just above ambient, left equal to ambient and so clamped.
        push_fixed(iracf_pkg::FUNC_CAPTURE, {12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
                                             12'd0, 12'd4095, 12'd0, 12'd4095});
        push_fixed(iracf_pkg::FUNC_TICK, '0);
        push_fixed(iracf_pkg::FUNC_TICK, '0);
        // Front ambient at both ends, full-scale battery.
        push_fixed(iracf_pkg::FUNC_CAPTURE, {12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095,
                                             12'd0, 12'd0, 12'd0, 12'd0});
        push_fixed(iracf_pkg::FUNC_TICK, '0);
        push_fixed(iracf_pkg::FUNC_TICK, '0);
        // Front right below ambient, front left at full scale.
        push_fixed(iracf_pkg::FUNC_CAPTURE, {12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0,
                                             12'd0, 12'd0, 12'd0, 12'd0});
        // Dark ambient, then full-scale emitter-on samples for both groups.
        for (int k = 0; k < 4; k++) begin
          push_fixed(iracf_pkg::FUNC_TICK, '0);
          push_fixed(iracf_pkg::FUNC_TICK, '0);
          push_fixed(iracf_pkg::FUNC_CAPTURE, (k % 2 == 0) ? '0 : {9{12'hFFF}});
        end
      end

      // Mostly well-formed tick, tick, completion rounds, some stray items.
      for (int n = 0; n < ROUNDS_EACH; ) begin
        if ($urandom_range(99) < 88) begin
          sensor_items.push_back(random_item(iracf_pkg::FUNC_TICK));
          sensor_items.push_back(random_item(iracf_pkg::FUNC_TICK));
          sensor_items.push_back(random_item(iracf_pkg::FUNC_CAPTURE));
          n++;
        end else begin
          sensor_items.push_back(random_item($urandom_range(1, 0) ?
                                             iracf_pkg::FUNC_CAPTURE :
                                             iracf_pkg::FUNC_TICK));
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_levels.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
hdl/iracf_pkg.sv
hdl/iracf_div.sv
hdl/ir_sensor_ambient_cancel_filter.sv
bench/tb_ir_sensor_ambient_cancel_filter.sv
